/* src/psm_pkg.sv */
// shared types, constants and constant functions for the sample mutation pipeline
`default_nettype none
package psm_pkg;

    localparam int          DEF_FRAC_BITS = 24;
    localparam int          INV_W         = 16;
    localparam logic [15:0] FINE_RESET    = 16'd1024;

    // bit-serial square root cell state
    typedef struct packed {
        logic [63:0] x;
        logic [32:0] rem;
        logic [31:0] root;
    } t_sqrt_st;

    // log2 squaring cell state, mantissa in [1,2) as q.30, result q4.30
    typedef struct packed {
        logic [30:0] m;
        logic [33:0] acc;
    } t_log_st;

    // 2^-x cell state, exponent q4.30, product q1.32
    typedef struct packed {
        logic [33:0] x;
        logic [32:0] acc;
    } t_exp_st;

    // restoring divider cell state
    typedef struct packed {
        logic [32:0] n;
        logic [15:0] rem;
        logic [15:0] den;
    } t_div_st;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-j) in q0.32, each one the floored root of the one before
    function automatic logic [31:0] exp_root(input int j);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int i = 1; i <= j; i++) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

endpackage
`default_nettype wire

/* src/psm_sqrt_cell.sv */
// one result bit of the integer square root
`default_nettype none
module psm_sqrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire psm_pkg::t_sqrt_st  i_d,
    output psm_pkg::t_sqrt_st       o_q
);
    logic [34:0] w;
    logic [34:0] trial;
    psm_pkg::t_sqrt_st n_q;

    always_comb begin
        w     = {i_d.rem, i_d.x[63:62]};
        trial = {1'b0, i_d.root, 2'b01};
        n_q.x = {i_d.x[61:0], 2'b00};
        if (w >= trial) begin
            n_q.rem  = 33'(w - trial);
            n_q.root = {i_d.root[30:0], 1'b1};
        end else begin
            n_q.rem  = w[32:0];
            n_q.root = {i_d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule
`default_nettype wire

/* src/psm_log_cell.sv */
// one fraction bit of log2 by squaring the mantissa
`default_nettype none
module psm_log_cell #(
    parameter int BIT = 29
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire psm_pkg::t_log_st  i_d,
    output psm_pkg::t_log_st       o_q
);
    logic [61:0] sq;
    psm_pkg::t_log_st n_q;

    always_comb begin
        sq    = 62'(i_d.m) * 62'(i_d.m);
        n_q   = i_d;
        if (sq[61]) begin
            n_q.m        = sq[61:31];
            n_q.acc[BIT] = 1'b1;
        end else begin
            n_q.m = sq[60:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule
`default_nettype wire

/* src/psm_exp_cell.sv */
// one exponent bit of 2^-x, multiply by a fixed root of one half
`default_nettype none
module psm_exp_cell #(
    parameter int J = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire psm_pkg::t_exp_st  i_d,
    output psm_pkg::t_exp_st       o_q
);
    localparam logic [31:0] KC = psm_pkg::exp_root(J);

    logic [64:0] prod;
    psm_pkg::t_exp_st n_q;

    always_comb begin
        prod = 65'(i_d.acc) * 65'(KC);
        n_q  = i_d;
        if (i_d.x[30-J]) begin
            n_q.acc = prod[64:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule
`default_nettype wire

/* src/psm_div_cell.sv */
// one quotient bit of restoring division
`default_nettype none
module psm_div_cell (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire psm_pkg::t_div_st  i_d,
    output psm_pkg::t_div_st       o_q
);
    logic [16:0] w;
    logic        q;
    psm_pkg::t_div_st n_q;

    always_comb begin
        w       = {i_d.rem, i_d.n[32]};
        q       = (w >= {1'b0, i_d.den});
        n_q.den = i_d.den;
        n_q.n   = {i_d.n[31:0], q};
        n_q.rem = q ? 16'(w - {1'b0, i_d.den}) : w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end
endmodule
`default_nettype wire

/* src/primary_sample_mutation_top.sv */
// top level of the primary sample space mutation pipeline
`default_nettype none
// Mutates one Q1.FRAC_BITS sample coordinate per clock cycle unless stalled, Kelemen
// style: the step (1/c)*((c/f)^sqrt(r) - c/f) is added when the direction fraction is
// below one half and subtracted otherwise, wrapping into the unit interval. The datapath
// is a row of small cells: 32 square root cells run beside 30 log2 squaring cells for
// each of the fine and coarse inverses, then a two-stage split multiply, 30 exponent
// cells per operand, and 33 restoring division cells, then rounding and the wrap. A new
// item can enter every cycle that o_in_stall is low; the depth is set by the bit-serial
// root and divider and the two squaring/exponent rows. An output register plus one skid
// register decouple the two sides, so input stall only rises after an item arrives while
// the output is valid and stalled. The user must write the fine step inverse through
// the config port only while no item is in flight; the block does not enforce it.
module primary_sample_mutation_top #(
    parameter int FRAC_BITS = psm_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [psm_pkg::INV_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [FRAC_BITS:0]            i_sample_value,
    input  wire logic [FRAC_BITS-1:0]          i_step_random,
    input  wire logic [FRAC_BITS-1:0]          i_direction_random,
    input  wire logic [psm_pkg::INV_W-1:0]     i_coarse_step_inverse,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [FRAC_BITS:0]                 o_mutated_value
);
    localparam int                 SH    = 32 - FRAC_BITS;
    localparam int                 LAST  = 100;
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // msb position gives the integer part, mantissa normalized to [1,2)
    function automatic psm_pkg::t_log_st log_init(input logic [15:0] n);
        psm_pkg::t_log_st r;
        logic [3:0]       k;
        k = '0;
        for (int b = 1; b < 16; b++) begin
            if (n[b]) k = 4'(b);
        end
        r.m   = 31'(n) << (5'd30 - 5'(k));
        r.acc = {k, 30'b0};
        return r;
    endfunction

    logic        en;
    logic [15:0] r_fine;

    // stage valid bits and side data riding along the row
    logic [LAST:0]      r_vld;
    logic [FRAC_BITS:0] r_sv   [0:99];
    logic               r_add  [0:99];
    logic [15:0]        r_c    [0:64];
    logic               r_skip [0:64];

    // input stage conditioning
    logic [FRAC_BITS:0] in_sat;
    logic [15:0]        in_c;
    logic [15:0]        in_f;

    psm_pkg::t_sqrt_st r_sq0;
    psm_pkg::t_log_st  r_lf0, r_lc0;
    psm_pkg::t_sqrt_st w_sq [0:32];
    psm_pkg::t_log_st  w_lf [0:30];
    psm_pkg::t_log_st  w_lc [0:30];

    logic [33:0] r_d31, r_d32, r_d33;
    logic [46:0] r_plo, r_phi;
    logic [63:0] e_full;

    psm_pkg::t_exp_st r_ea0, r_eb0;
    psm_pkg::t_exp_st w_ea [0:30];
    psm_pkg::t_exp_st w_eb [0:30];

    logic [32:0] exp_a, exp_b;
    psm_pkg::t_div_st r_dv0;
    psm_pkg::t_div_st n_dv0;
    psm_pkg::t_div_st w_dv [0:33];

    logic [33:0]        rounded;
    logic [FRAC_BITS:0] r_dvq;
    logic [FRAC_BITS:0] n_dvq;
    logic [FRAC_BITS+1:0] sum;
    logic [FRAC_BITS+1:0] mut;
    logic [FRAC_BITS:0] r_res;

    logic [FRAC_BITS:0] r_out, r_skid;
    logic               r_out_valid, r_skid_valid;

    // the whole row moves unless the skid register already holds an item
    assign en          = !r_skid_valid;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_mutated_value = r_out;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine <= psm_pkg::FINE_RESET;
        end else if (i_cfg_we) begin
            r_fine <= i_cfg_wdata;
        end
    end

    always_comb begin
        in_sat = (i_sample_value > ONE_Q) ? ONE_Q : i_sample_value;
        in_c   = (i_coarse_step_inverse == '0) ? 16'd1 : i_coarse_step_inverse;
        in_f   = (r_fine == '0) ? 16'd1 : r_fine;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    // side data shift, the log compare folds into skip at stage 31
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sv[0]   <= in_sat;
            r_add[0]  <= !i_direction_random[FRAC_BITS-1];
            r_c[0]    <= in_c;
            r_skip[0] <= (in_c >= in_f);
            for (int k = 1; k < 100; k++) begin
                r_sv[k]  <= r_sv[k-1];
                r_add[k] <= r_add[k-1];
            end
            for (int k = 1; k <= 64; k++) begin
                r_c[k]    <= r_c[k-1];
                r_skip[k] <= r_skip[k-1] |
                             ((k == 31) & (w_lf[30].acc <= w_lc[30].acc));
            end
        end
    end

    // stage 0 cell inputs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq0.x    <= {i_step_random, {(64-FRAC_BITS){1'b0}}};
            r_sq0.rem  <= '0;
            r_sq0.root <= '0;
            r_lf0      <= log_init(in_f);
            r_lc0      <= log_init(in_c);
        end
    end

    assign w_sq[0] = r_sq0;
    assign w_lf[0] = r_lf0;
    assign w_lc[0] = r_lc0;

    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        psm_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sq[k]),
            .o_q   (w_sq[k+1])
        );
    end

    for (genvar k = 0; k < 30; k++) begin : g_log
        psm_log_cell #(.BIT(29 - k)) u_lf (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_lf[k]),
            .o_q   (w_lf[k+1])
        );
        psm_log_cell #(.BIT(29 - k)) u_lc (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_lc[k]),
            .o_q   (w_lc[k+1])
        );
    end

    // log difference, split multiply by sqrt(r), then the exponent start
    assign e_full = 64'(r_plo) + (64'(r_phi) << 17);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d31 <= w_lf[30].acc - w_lc[30].acc;
            r_d32 <= r_d31;
            r_d33 <= r_d32;
            r_plo <= 47'(w_sq[32].root[31:2]) * 47'(r_d32[16:0]);
            r_phi <= 47'(w_sq[32].root[31:2]) * 47'(r_d32[33:17]);
            r_ea0.x   <= e_full[63:30];
            r_ea0.acc <= 33'h1_0000_0000;
            r_eb0.x   <= r_d33;
            r_eb0.acc <= 33'h1_0000_0000;
        end
    end

    assign w_ea[0] = r_ea0;
    assign w_eb[0] = r_eb0;

    for (genvar j = 1; j <= 30; j++) begin : g_exp
        psm_exp_cell #(.J(j)) u_ea (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_ea[j-1]),
            .o_q   (w_ea[j])
        );
        psm_exp_cell #(.J(j)) u_eb (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_eb[j-1]),
            .o_q   (w_eb[j])
        );
    end

    // integer part of the exponent is a plain right shift
    always_comb begin
        exp_a     = w_ea[30].acc >> w_ea[30].x[33:30];
        exp_b     = w_eb[30].acc >> w_eb[30].x[33:30];
        n_dv0.rem = '0;
        n_dv0.den = r_c[64];
        if (r_skip[64] || (exp_a <= exp_b)) begin
            n_dv0.n = '0;
        end else begin
            n_dv0.n = exp_a - exp_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv0 <= n_dv0;
        end
    end

    assign w_dv[0] = r_dv0;

    for (genvar k = 0; k < 33; k++) begin : g_div
        psm_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_dv[k]),
            .o_q   (w_dv[k+1])
        );
    end

    // round to FRAC_BITS, ties up
    if (SH > 0) begin : g_round
        assign rounded = (34'(w_dv[33].n) + (34'(1) << (SH - 1))) >> SH;
    end else begin : g_noround
        assign rounded = 34'(w_dv[33].n);
    end

    assign n_dvq = (rounded > 34'(ONE_Q)) ? ONE_Q : rounded[FRAC_BITS:0];

    // add with wrap above one, or subtract with wrap below zero
    always_comb begin
        sum = {1'b0, r_sv[99]} + {1'b0, r_dvq};
        if (r_add[99]) begin
            mut = (sum > {1'b0, ONE_Q}) ? sum - {1'b0, ONE_Q} : sum;
        end else if (r_dvq > r_sv[99]) begin
            mut = sum - {r_dvq, 1'b0} + {1'b0, ONE_Q};
        end else begin
            mut = {1'b0, r_sv[99]} - {1'b0, r_dvq};
        end
        if (mut > {1'b0, ONE_Q}) begin
            mut = {1'b0, ONE_Q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvq <= n_dvq;
            r_res <= mut[FRAC_BITS:0];
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid  <= r_skid_valid || (en && r_vld[LAST]);
            r_skid_valid <= 1'b0;
        end else if (en && r_vld[LAST]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : r_res;
        end else if (en && r_vld[LAST]) begin
            r_skid <= r_res;
        end
    end
endmodule
`default_nettype wire

/* src/psm_checker.sv */
// port level checks for the sample mutation pipeline, bound to the top level
`default_nettype none
module psm_checker #(
    parameter int FRAC_BITS = psm_pkg::DEF_FRAC_BITS
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [FRAC_BITS:0]        o_mutated_value
);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or stall after reset");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mutated_value <= ONE_Q)
        else $error("mutated value above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mutated_value))
        else $error("stalled item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall without a held output item");

    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("skid not drained when output was taken");
endmodule

bind primary_sample_mutation_top psm_checker #(.FRAC_BITS(FRAC_BITS)) u_psm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_mutated_value (o_mutated_value)
);
`default_nettype wire
